### hdl/jacobi_laplace_stencil_sweep_unit_macros.svh
// Assertion macros for the Jacobi stencil sweep unit and its checker
`ifndef JACOBI_LAPLACE_STENCIL_SWEEP_UNIT_MACROS_SVH
`define JACOBI_LAPLACE_STENCIL_SWEEP_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define JLSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jlss: same-cycle check failed");

// next-cycle implication, off while in reset
`define JLSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jlss: next-cycle check failed");

// next-cycle implication that also covers reset itself
`define JLSS_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("jlss: reset check failed");

`endif

### hdl/jlss_pkg.sv
// Shared constants, types and functions of the Jacobi stencil sweep unit
package jlss_pkg;

  localparam int DATA_W  = 32;
  localparam int CFG_W   = 13;
  localparam int PADDR_W = 3;
  localparam int APB_W   = 32;

  localparam int DEF_MAX_ROW_LENGTH = 4096;
  localparam int DEF_MAX_ROWS       = 4096;
  localparam logic [CFG_W-1:0] SIZE_RESET = 13'd4096;
  localparam int MIN_SIZE = 3;

  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_ROW_COUNT  = 1'b1;

  typedef struct packed {
    logic upper;     // emits the cell above
    logic border;    // cell above is a border cell
    logic last_row;  // also emits this cell
    logic last_col;
  } flags_t;

  // last index of a dimension after limiting the size to [3, max]
  function automatic int unsigned clamp_last(input logic [CFG_W-1:0] v, input int unsigned max);
    int unsigned size;
    size = int'(v);
    if (size < MIN_SIZE) size = MIN_SIZE;
    if (size > max) size = max;
    return size - 1;
  endfunction

endpackage

### hdl/jacobi_laplace_stencil_sweep_unit.sv
// Jacobi 5-point Laplace stencil sweep over a raster-order grid stream
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, cell_value            | in
//  output  | out_valid, out_ready, new_value, frame_done | out
//  config  | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB
//
//  One cell per cycle while the output is not stalled; last-row cells give two results, one at a time.
//  Line store read on acceptance into stage 1, result registered in the output stage.
//  Rate is set by the single output stage and the registered store read.
//  Reset clears control only; line stores need no clearing pass.
//  A stalled output holds one item and stage 1 a second; the input then stalls.
module jacobi_laplace_stencil_sweep_unit #(
  parameter int MAX_ROW_LENGTH = jlss_pkg::DEF_MAX_ROW_LENGTH,
  parameter int MAX_ROWS       = jlss_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [jlss_pkg::DATA_W-1:0] cell_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [jlss_pkg::DATA_W-1:0] new_value,
  output logic                               frame_done,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [jlss_pkg::PADDR_W-1:0]       paddr,
  input  logic [jlss_pkg::APB_W-1:0]         pwdata,
  output logic [jlss_pkg::APB_W-1:0]         prdata,
  output logic                               pready
);

  localparam int COL_W = $clog2(MAX_ROW_LENGTH);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int DW    = jlss_pkg::DATA_W;

  logic [jlss_pkg::CFG_W-1:0] row_length;
  logic [jlss_pkg::CFG_W-1:0] row_count;
  logic [COL_W-1:0]           last_col;
  logic [ROW_W-1:0]           last_row;
  logic [COL_W-1:0]           col;
  logic [ROW_W-1:0]           row;

  logic [DW-1:0] newer_row [MAX_ROW_LENGTH];
  logic [DW-1:0] older_row [MAX_ROW_LENGTH];
  logic [DW-1:0] rd_center;
  logic [DW-1:0] rd_east;
  logic [DW-1:0] rd_north;
  logic [DW-1:0] west;

  logic             s1_valid;
  logic [DW-1:0]    s1_x;
  logic [COL_W-1:0] s1_col;
  jlss_pkg::flags_t s1_flags;
  jlss_pkg::flags_t in_flags;

  logic          v0;
  logic          v1;
  logic [DW-1:0] d0;
  logic [DW-1:0] d1;
  logic          fd1;

  logic             cfg_write;
  logic             in_fire;
  logic             out_fire;
  logic             s2_free;
  logic             s1_adv;
  logic [COL_W-1:0] east_addr;
  logic [DW+1:0]    sum;
  logic [DW-1:0]    upper_value;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == jlss_pkg::REG_ROW_COUNT) ?
                     jlss_pkg::APB_W'(row_count) : jlss_pkg::APB_W'(row_length);

  assign out_valid  = v0 | v1;
  assign new_value  = v0 ? d0 : d1;
  assign frame_done = ~v0 & v1 & fd1;
  assign out_fire   = out_valid & out_ready;

  assign s2_free  = ~out_valid | (out_fire & ~(v0 & v1));
  assign s1_adv   = s1_valid & s2_free;
  assign in_ready = ~s1_valid | s2_free;
  assign in_fire  = in_valid & in_ready;

  assign east_addr = (col == last_col) ? col : col + COL_W'(1);

  always_comb begin
    in_flags.upper    = (row != '0);
    in_flags.border   = (row == ROW_W'(1)) | (col == '0) | (col == last_col);
    in_flags.last_row = (row == last_row);
    in_flags.last_col = (col == last_col);
  end

  // north + south + west + east, exact in 34 bits; floor divide by 4
  assign sum = {{2{rd_north[DW-1]}}, rd_north} + {{2{s1_x[DW-1]}}, s1_x}
             + {{2{west[DW-1]}}, west} + {{2{rd_east[DW-1]}}, rd_east};
  assign upper_value = s1_flags.border ? rd_center : sum[DW+1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= jlss_pkg::SIZE_RESET;
      row_count  <= jlss_pkg::SIZE_RESET;
      last_col   <= COL_W'(jlss_pkg::clamp_last(jlss_pkg::SIZE_RESET, MAX_ROW_LENGTH));
      last_row   <= ROW_W'(jlss_pkg::clamp_last(jlss_pkg::SIZE_RESET, MAX_ROWS));
      col        <= '0;
      row        <= '0;
    end else if (cfg_write) begin
      col <= '0;
      row <= '0;
      if (paddr[2] == jlss_pkg::REG_ROW_COUNT) begin
        row_count <= pwdata[jlss_pkg::CFG_W-1:0];
        last_row  <= ROW_W'(jlss_pkg::clamp_last(pwdata[jlss_pkg::CFG_W-1:0], MAX_ROWS));
      end else begin
        row_length <= pwdata[jlss_pkg::CFG_W-1:0];
        last_col   <= COL_W'(jlss_pkg::clamp_last(pwdata[jlss_pkg::CFG_W-1:0], MAX_ROW_LENGTH));
      end
    end else if (in_fire) begin
      if (col == last_col) begin
        col <= '0;
        row <= (row == last_row) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // line stores: read on acceptance, write back when the item leaves stage 1
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_center <= newer_row[col];
      rd_east   <= newer_row[east_addr];
      rd_north  <= older_row[col];
    end
    if (s1_adv) begin
      newer_row[s1_col] <= s1_x;
      older_row[s1_col] <= rd_center;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x     <= cell_value;
      s1_col   <= col;
      s1_flags <= in_flags;
    end
    if (s1_adv) begin
      west <= rd_center;
      d0   <= upper_value;
      d1   <= s1_x;
      fd1  <= s1_flags.last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (s1_adv) begin
      v0 <= s1_flags.upper;
      v1 <= s1_flags.last_row;
    end else if (out_fire) begin
      if (v0) begin
        v0 <= 1'b0;
      end else begin
        v1 <= 1'b0;
      end
    end
  end

endmodule

### hdl/jlss_checker.sv
// Port-level checker for the Jacobi stencil sweep unit, with its bind
`include "jacobi_laplace_stencil_sweep_unit_macros.svh"

module jlss_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [jlss_pkg::DATA_W-1:0] new_value,
  input logic                               frame_done
);

  // a held result keeps its payload
  `JLSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_value) && $stable(frame_done))

  // end-of-frame flag only travels with a result
  `JLSS_ASSERT_NOW(a_done_valid, frame_done, out_valid)

  // an empty output stage never blocks input
  `JLSS_ASSERT_NOW(a_ready_empty, !out_valid, in_ready)

  // reset leaves no result and an open input
  `JLSS_ASSERT_RESET(a_reset_clear, rst, !out_valid && in_ready)

endmodule

bind jacobi_laplace_stencil_sweep_unit jlss_checker u_jlss_checker (.*);
